// ----- rtl/tsq_pkg.sv -----
// shared types and constants for the two-stack queue
`default_nettype none

package tsq_pkg;

  localparam int unsigned STACK_DEPTH = 128;
  localparam int unsigned DATA_W      = 32;

  localparam logic MODE_ENQUEUE = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED  = 2'd0,
    ST_DEQUEUED  = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_XFER,
    S_LAST
  } state_t;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    status_t                  status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/two_stack_fifo_queue_core.sv -----
// two-stack fifo queue: input and output stacks in synchronous memories
//
//  channel | direction | beat  | fields
//  req     | in        | req_t | mode, data_in
//  rsp     | out       | rsp_t | data_out, status
//
// enqueue, overflow and underflow: handled in idle, results every cycle while the result stage can drain
// dequeue from a non-empty output stack: a registered memory read, then the pop state
// dequeue that refills the output stack: the xfer state reads the n entries on the
//   input stack, one entry a cycle through the input stack read port
// reset clears both counts; the memories need no clearing
// rsp stalls are absorbed by a result stage; req stalls while a dequeue is in
//   flight and when that stage cannot drain
`default_nettype none

module two_stack_fifo_queue_core #(
  parameter int unsigned STACK_DEPTH = tsq_pkg::STACK_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire tsq_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output tsq_pkg::rsp_t      rsp
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = tsq_pkg::DATA_W;

  // control registers
  tsq_pkg::state_t state, state_next;
  logic [CW-1:0]   in_cnt, in_cnt_next;
  logic [CW-1:0]   out_cnt, out_cnt_next;
  logic            xfer_rv, xfer_rv_next;
  logic            res_valid, res_valid_next;
  logic            rsp_valid_next;

  // payload registers
  tsq_pkg::rsp_t   res, res_next;

  // memory ports
  logic [DW-1:0] in_mem [STACK_DEPTH];
  logic [DW-1:0] out_mem [STACK_DEPTH];
  logic          in_wr_en, in_rd_en, out_wr_en, out_rd_en;
  logic [IW-1:0] in_rd_addr, out_rd_addr;
  logic [DW-1:0] in_rd_data, out_rd_data;

  logic [CW-1:0] in_cnt_dec, out_cnt_dec;
  logic          res_move;

  assign in_cnt_dec  = in_cnt - CW'(1);
  assign out_cnt_dec = out_cnt - CW'(1);
  assign in_rd_addr  = in_cnt_dec[IW-1:0];
  assign out_rd_addr = out_cnt_dec[IW-1:0];

  // result stage hands over to the output register when it is free
  assign res_move  = res_valid && (!rsp_valid || rsp_ready);
  assign req_ready = (state == tsq_pkg::S_IDLE) && (!res_valid || res_move);

  // next state, counts and memory strobes
  always_comb begin
    state_next     = state;
    in_cnt_next    = in_cnt;
    out_cnt_next   = out_cnt;
    xfer_rv_next   = 1'b0;
    res_valid_next = res_valid && !res_move;
    res_next       = res;
    in_wr_en       = 1'b0;
    in_rd_en       = 1'b0;
    out_wr_en      = 1'b0;
    out_rd_en      = 1'b0;
    unique case (state)
      tsq_pkg::S_IDLE: begin
        if (req_valid && req_ready) begin
          if (req.mode == tsq_pkg::MODE_ENQUEUE) begin
            res_valid_next = 1'b1;
            if (in_cnt == CW'(STACK_DEPTH)) begin
              res_next = '{data_out: '0, status: tsq_pkg::ST_OVERFLOW};
            end else begin
              in_wr_en    = 1'b1;
              in_cnt_next = in_cnt + CW'(1);
              res_next    = '{data_out: '0, status: tsq_pkg::ST_ENQUEUED};
            end
          end else if (out_cnt != '0) begin
            out_rd_en    = 1'b1;
            out_cnt_next = out_cnt_dec;
            state_next   = tsq_pkg::S_POP;
          end else if (in_cnt == '0) begin
            res_valid_next = 1'b1;
            res_next       = '{data_out: '0, status: tsq_pkg::ST_UNDERFLOW};
          end else begin
            state_next = tsq_pkg::S_XFER;
          end
        end
      end
      tsq_pkg::S_POP: begin
        res_valid_next = 1'b1;
        res_next       = '{data_out: out_rd_data, status: tsq_pkg::ST_DEQUEUED};
        state_next     = tsq_pkg::S_IDLE;
      end
      tsq_pkg::S_XFER: begin
        // write back the entry read last cycle, read the next one down
        if (xfer_rv) begin
          out_wr_en    = 1'b1;
          out_cnt_next = out_cnt + CW'(1);
        end
        in_rd_en     = 1'b1;
        in_cnt_next  = in_cnt_dec;
        xfer_rv_next = 1'b1;
        if (in_cnt == CW'(1)) begin
          state_next = tsq_pkg::S_LAST;
        end
      end
      tsq_pkg::S_LAST: begin
        // oldest entry goes straight out and is never stored
        res_valid_next = 1'b1;
        res_next       = '{data_out: in_rd_data, status: tsq_pkg::ST_DEQUEUED};
        state_next     = tsq_pkg::S_IDLE;
      end
      default: begin
        state_next = tsq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (res_move) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsq_pkg::S_IDLE;
      in_cnt    <= '0;
      out_cnt   <= '0;
      xfer_rv   <= 1'b0;
      res_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_cnt    <= in_cnt_next;
      out_cnt   <= out_cnt_next;
      xfer_rv   <= xfer_rv_next;
      res_valid <= res_valid_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res <= res_next;
    if (res_move) begin
      rsp <= res;
    end
  end

  // input stack memory
  always_ff @(posedge clk) begin
    if (in_wr_en) begin
      in_mem[in_cnt[IW-1:0]] <= req.data_in;
    end
    if (in_rd_en) begin
      in_rd_data <= in_mem[in_rd_addr];
    end
  end

  // output stack memory
  always_ff @(posedge clk) begin
    if (out_wr_en) begin
      out_mem[out_cnt[IW-1:0]] <= in_rd_data;
    end
    if (out_rd_en) begin
      out_rd_data <= out_mem[out_rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_in_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    in_cnt <= CW'(STACK_DEPTH))
    else $error("input stack count beyond depth");

  a_out_cnt_bound : assert property (@(posedge clk) disable iff (rst)
    out_cnt <= CW'(STACK_DEPTH))
    else $error("output stack count beyond depth");

  a_pop_from_idle : assert property (@(posedge clk) disable iff (rst)
    state == tsq_pkg::S_POP |-> $past(state) == tsq_pkg::S_IDLE)
    else $error("pop stage entered from outside idle");

  a_last_drained : assert property (@(posedge clk) disable iff (rst)
    state == tsq_pkg::S_LAST |-> in_cnt == '0)
    else $error("transfer finished with entries left on the input stack");

  a_no_result_in_xfer : assert property (@(posedge clk) disable iff (rst)
    (state == tsq_pkg::S_POP || state == tsq_pkg::S_XFER || state == tsq_pkg::S_LAST)
      |-> !res_valid)
    else $error("result staged while a dequeue is still in flight");
`endif

endmodule

`default_nettype wire
